>>> rtl/core/lle_pkg.sv
package lle_pkg;

    // Default store depth
    localparam int CAPACITY_DEF = 16;

    localparam int ACT_W  = 3;
    localparam int DATA_W = 32;
    localparam int STAT_W = 2;

    // Request actions
    localparam logic [ACT_W-1:0] ACT_INS_FRONT = 3'd0;
    localparam logic [ACT_W-1:0] ACT_INS_BACK  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_INS_AFTER = 3'd2;
    localparam logic [ACT_W-1:0] ACT_DEL_FRONT = 3'd3;
    localparam logic [ACT_W-1:0] ACT_DEL_BACK  = 3'd4;
    localparam logic [ACT_W-1:0] ACT_DEL_KEY   = 3'd5;
    localparam logic [ACT_W-1:0] ACT_SEARCH    = 3'd6;
    localparam logic [ACT_W-1:0] ACT_TRAVERSE  = 3'd7;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL     = 2'd3;

    // Command broadcast to every cell
    typedef struct packed {
        logic              commit;
        logic [ACT_W-1:0]  op;
        logic [DATA_W-1:0] key;
        logic [DATA_W-1:0] value;
    } lle_cmd_t;

    // Search wave moving one cell per cycle
    typedef struct packed {
        logic valid;
        logic hit;
    } lle_wave_t;

    // What a cell shows its neighbours
    typedef struct packed {
        logic              occ;
        logic [DATA_W-1:0] val;
        logic              first;
    } lle_nbr_t;

endpackage

>>> rtl/core/lle_cell.sv
module lle_cell import lle_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  lle_cmd_t  cmd,
    input  lle_wave_t wave_in,
    output lle_wave_t wave_out,
    input  lle_nbr_t  left_in,
    input  lle_nbr_t  right_in,
    output lle_nbr_t  cell_out
);

    logic              occ_reg, occ_next;
    logic [DATA_W-1:0] val_reg, val_next;
    logic              hb_reg, hb_next;
    lle_wave_t         wave_reg, wave_next;
    logic              match;
    logic              first;

    // Key compare; first match is a match with no earlier hit
    assign match = occ_reg && (val_reg == cmd.key);
    assign first = match && !hb_reg;

    // Wave: record whether an earlier cell matched, pass hit on
    always_comb begin
        wave_next.valid = wave_in.valid;
        wave_next.hit   = wave_in.hit | match;
        hb_next         = wave_in.valid ? wave_in.hit : hb_reg;
    end

    // Commit: each cell takes from itself, a neighbour or the command value
    always_comb begin
        occ_next = occ_reg;
        val_next = val_reg;
        if (cmd.commit) begin
            case (cmd.op)
                ACT_INS_FRONT: begin
                    occ_next = left_in.occ;
                    val_next = left_in.val;
                end
                ACT_INS_BACK: begin
                    if (!occ_reg && left_in.occ) begin
                        occ_next = 1'b1;
                        val_next = cmd.value;
                    end
                end
                ACT_INS_AFTER: begin
                    if (hb_reg) begin
                        if (left_in.first) begin
                            occ_next = 1'b1;
                            val_next = cmd.value;
                        end else begin
                            occ_next = left_in.occ;
                            val_next = left_in.val;
                        end
                    end
                end
                ACT_DEL_FRONT, ACT_TRAVERSE: begin
                    occ_next = right_in.occ;
                    val_next = right_in.val;
                end
                ACT_DEL_BACK: begin
                    if (occ_reg && !right_in.occ) begin
                        occ_next = 1'b0;
                    end
                end
                ACT_DEL_KEY: begin
                    if (first || hb_reg) begin
                        occ_next = right_in.occ;
                        val_next = right_in.val;
                    end
                end
                default: begin
                    occ_next = occ_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg  <= 1'b0;
            hb_reg   <= 1'b0;
            wave_reg <= '0;
        end else begin
            occ_reg  <= occ_next;
            hb_reg   <= hb_next;
            wave_reg <= wave_next;
        end
    end

    always_ff @(posedge aclk) begin
        val_reg <= val_next;
    end

    assign wave_out       = wave_reg;
    assign cell_out.occ   = occ_reg;
    assign cell_out.val   = val_reg;
    assign cell_out.first = first;

endmodule

>>> rtl/core/linked_list_engine_top.sv
// Channel  Dir  Ports                       Contents
// s_       in   tvalid tready tdata tuser   tdata: key[31:0] value[63:32]; tuser: action
// m_       out  tvalid tready tdata tuser   tdata: item_value; tuser: status, found
//                tlast                       tlast: last result of the request
//
// The list is held in order in a row of CAPACITY cells, the head in cell 0.
// Non-traverse requests send a key wave along the row one cell per cycle,
// then commit any shift and load the result once the result register is free.
// Traverse turns the ring once, emitting each occupied cell, and waits while the
// output stalls; a traverse of an empty list answers with an empty status.
// Reset empties every cell and clears the count; values are not cleared.
// A result register parts the two sides; a stalled m_ side holds the commit and the ring walk.
module linked_list_engine_top import lle_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // key[31:0], value[63:32]
    input  logic [2:0]  s_tuser,   // action[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // item_value[31:0]
    output logic [2:0]  m_tuser,   // status[1:0], found[2]
    output logic        m_tlast
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WAVE = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;
    localparam logic [1:0] S_TRAV = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [ACT_W-1:0]  op_reg, op_next;
    logic [DATA_W-1:0] key_reg, key_next;
    logic [DATA_W-1:0] value_reg, value_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  step_reg, step_next;
    logic [CNT_W-1:0]  emit_reg, emit_next;
    logic              found_reg, found_next;
    logic              wave_start_reg, wave_start_next;

    logic              m_valid_reg;
    logic [STAT_W-1:0] m_status_reg, out_status;
    logic              m_found_reg, out_found;
    logic [DATA_W-1:0] m_value_reg, out_value;
    logic              m_last_reg, out_last;
    logic              out_load;

    logic              accept;
    logic              slot_free;
    logic              full;
    logic              empty;
    logic              cmd_commit;
    logic              rotate;
    logic [STAT_W-1:0] done_status;
    lle_cmd_t          cmd;
    lle_nbr_t          cell_q [CAPACITY];
    lle_wave_t         wave_q [CAPACITY];
    logic [CAPACITY-1:0] occ_vec;

    assign s_tready  = (state_reg == S_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign slot_free = !m_valid_reg || m_tready;
    assign full      = (count_reg == CNT_W'(CAPACITY));
    assign empty     = (count_reg == '0);
    assign rotate    = cmd_commit && (op_reg == ACT_TRAVERSE);

    assign cmd.commit = cmd_commit;
    assign cmd.op     = op_reg;
    assign cmd.key    = key_reg;
    assign cmd.value  = value_reg;

    // Row of cells: left of cell 0 carries the new value, ring closes on rotate
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        lle_nbr_t  left_in;
        lle_nbr_t  right_in;
        lle_wave_t wave_in;

        if (i == 0) begin : g_head
            assign left_in.occ   = 1'b1;
            assign left_in.val   = value_reg;
            assign left_in.first = 1'b0;
            assign wave_in.valid = wave_start_reg;
            assign wave_in.hit   = 1'b0;
        end else begin : g_body
            assign left_in = cell_q[i-1];
            assign wave_in = wave_q[i-1];
        end

        if (i == CAPACITY - 1) begin : g_tail
            assign right_in = rotate ? cell_q[0] : lle_nbr_t'('0);
        end else begin : g_mid
            assign right_in = cell_q[i+1];
        end

        lle_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .cmd      (cmd),
            .wave_in  (wave_in),
            .wave_out (wave_q[i]),
            .left_in  (left_in),
            .right_in (right_in),
            .cell_out (cell_q[i])
        );

        assign occ_vec[i] = cell_q[i].occ;
    end

    // Result of a single-result request
    always_comb begin
        case (op_reg)
            ACT_INS_FRONT, ACT_INS_BACK: done_status = full ? ST_FULL : ST_OK;
            ACT_INS_AFTER: done_status = !found_reg ? ST_NOTFOUND : (full ? ST_FULL : ST_OK);
            ACT_DEL_FRONT, ACT_DEL_BACK: done_status = empty ? ST_EMPTY : ST_OK;
            ACT_DEL_KEY: done_status = empty ? ST_EMPTY : (!found_reg ? ST_NOTFOUND : ST_OK);
            ACT_SEARCH: done_status = found_reg ? ST_OK : ST_NOTFOUND;
            default: done_status = ST_EMPTY;
        endcase
    end

    // Sequencer
    always_comb begin
        state_next      = state_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        value_next      = value_reg;
        count_next      = count_reg;
        step_next       = step_reg;
        emit_next       = emit_reg;
        found_next      = found_reg;
        wave_start_next = 1'b0;
        cmd_commit      = 1'b0;
        out_load        = 1'b0;
        out_status      = ST_OK;
        out_found       = 1'b0;
        out_value       = '0;
        out_last        = 1'b1;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    op_next    = s_tuser;
                    key_next   = s_tdata[31:0];
                    value_next = s_tdata[63:32];
                    step_next  = '0;
                    emit_next  = '0;
                    if (s_tuser == ACT_TRAVERSE) begin
                        state_next = empty ? S_DONE : S_TRAV;
                    end else begin
                        wave_start_next = 1'b1;
                        state_next      = S_WAVE;
                    end
                end
            end
            S_WAVE: begin
                if (wave_q[CAPACITY-1].valid) begin
                    found_next = wave_q[CAPACITY-1].hit;
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (slot_free) begin
                    out_load   = 1'b1;
                    out_status = done_status;
                    out_found  = (op_reg == ACT_SEARCH) && found_reg;
                    if (done_status == ST_OK && op_reg != ACT_SEARCH
                        && op_reg != ACT_TRAVERSE) begin
                        cmd_commit = 1'b1;
                        if (op_reg == ACT_INS_FRONT || op_reg == ACT_INS_BACK
                            || op_reg == ACT_INS_AFTER) begin
                            count_next = count_reg + CNT_W'(1);
                        end else begin
                            count_next = count_reg - CNT_W'(1);
                        end
                    end
                    state_next = S_IDLE;
                end
            end
            S_TRAV: begin
                // Cell 0 is emitted, then the ring turns by one
                if (!cell_q[0].occ || slot_free) begin
                    cmd_commit = 1'b1;
                    step_next  = step_reg + CNT_W'(1);
                    if (cell_q[0].occ) begin
                        out_load  = 1'b1;
                        out_value = cell_q[0].val;
                        out_last  = ((emit_reg + CNT_W'(1)) == count_reg);
                        emit_next = emit_reg + CNT_W'(1);
                    end
                    if (step_reg == CNT_W'(CAPACITY - 1)) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            step_reg       <= '0;
            emit_reg       <= '0;
            found_reg      <= 1'b0;
            wave_start_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            step_reg       <= step_next;
            emit_reg       <= emit_next;
            found_reg      <= found_next;
            wave_start_reg <= wave_start_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg    <= op_next;
        key_reg   <= key_next;
        value_reg <= value_next;
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_status_reg <= out_status;
            m_found_reg  <= out_found;
            m_value_reg  <= out_value;
            m_last_reg   <= out_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_value_reg;
    assign m_tuser  = {m_found_reg, m_status_reg};
    assign m_tlast  = m_last_reg;

    // Occupied cells agree with the count between requests
    a_count_match: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> ($countones(occ_vec) == int'(count_reg)))
        else $error("occupied cells differ from node count");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("node count above capacity");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg != S_IDLE))
        else $error("request accepted without starting work");

endmodule

>>> tb/sv/tb_linked_list_engine_top.sv
module tb_linked_list_engine_top;
    import lle_pkg::*;

    localparam int CAP          = CAPACITY_DEF;
    localparam int RANDOM_ITEMS = 100;
    localparam int CALM_ITEMS   = 20;    // tail of the run without idling
    localparam int LONG_HOLD    = 400;   // one long receiver hold-off
    localparam int HOLD_AFTER   = 40;    // results seen before that hold-off
    localparam int QUIET_LIMIT  = 2000;  // cycles without any transfer
    localparam int DRAIN_WAIT   = 2 * (CAP + 3);
    localparam int DIR_ROWS     = 22;

    typedef logic signed [DATA_W-1:0] word_t;

    localparam word_t W_MAX = 32'sh7fff_ffff;
    localparam word_t W_MIN = 32'sh8000_0000;

    // One result of a request
    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic              found;
        word_t             item_value;
        logic              last;
    } reply_t;

    // One row of directed stimulus; typed rows carry their own expected reply
    typedef struct packed {
        logic [ACT_W-1:0] act;
        word_t            key;
        word_t            value;
        logic             typed;
        reply_t           reply;
    } req_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;   // key[31:0], value[63:32]
    logic [2:0]  s_tuser;   // action[2:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // item_value[31:0]
    logic [2:0]  m_tuser;   // status[1:0], found[2]
    logic        m_tlast;

    // List contents in order, head first, and the replies still owed
    word_t    list_vals[$];
    reply_t   predicted[$];
    reply_t   pending_replies[$];
    req_row_t dir_rows[DIR_ROWS];

    int err_count       = 0;
    int results_checked = 0;
    int requests_sent   = 0;
    int max_depth       = 0;
    int full_refusals   = 0;
    int empty_errors    = 0;
    int key_misses      = 0;
    int traversals      = 0;
    bit no_idle         = 1'b0;
    bit rx_holding      = 1'b0;
    bit growing         = 1'b1;

    linked_list_engine_top #(.CAPACITY(CAP)) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // Clock
    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic reply_t make_reply(logic [STAT_W-1:0] st, logic fnd, word_t v,
                                          logic lst);
        reply_t r;
        r.status     = st;
        r.found      = fnd;
        r.item_value = v;
        r.last       = lst;
        return r;
    endfunction

    // Row with a typed single-result expectation
    function automatic req_row_t row_chk(logic [ACT_W-1:0] act, word_t key, word_t val,
                                         logic [STAT_W-1:0] st, logic fnd);
        req_row_t r;
        r.act   = act;
        r.key   = key;
        r.value = val;
        r.typed = 1'b1;
        r.reply = make_reply(st, fnd, '0, 1'b1);
        return r;
    endfunction

    // Row checked against the list model
    function automatic req_row_t row_pred(logic [ACT_W-1:0] act, word_t key, word_t val);
        req_row_t r;
        r.act   = act;
        r.key   = key;
        r.value = val;
        r.typed = 1'b0;
        r.reply = '0;
        return r;
    endfunction

    function automatic int first_holding(word_t key);
        for (int i = 0; i < list_vals.size(); i++)
            if (list_vals[i] == key)
                return i;
        return -1;
    endfunction

    // List model: applies one request and leaves its replies in predicted
    function automatic void apply_request(logic [ACT_W-1:0] act, word_t key, word_t val);
        int idx;
        logic [STAT_W-1:0] st;
        logic fnd;
        st  = ST_OK;
        fnd = 1'b0;
        predicted.delete();
        case (act)
            ACT_INS_FRONT: begin
                if (list_vals.size() >= CAP) st = ST_FULL;
                else list_vals.push_front(val);
            end
            ACT_INS_BACK: begin
                if (list_vals.size() >= CAP) st = ST_FULL;
                else list_vals.push_back(val);
            end
            ACT_INS_AFTER: begin
                // key sought before the capacity check
                idx = first_holding(key);
                if (idx < 0) st = ST_NOTFOUND;
                else if (list_vals.size() >= CAP) st = ST_FULL;
                else list_vals.insert(idx + 1, val);
            end
            ACT_DEL_FRONT: begin
                if (list_vals.size() == 0) st = ST_EMPTY;
                else void'(list_vals.pop_front());
            end
            ACT_DEL_BACK: begin
                if (list_vals.size() == 0) st = ST_EMPTY;
                else void'(list_vals.pop_back());
            end
            ACT_DEL_KEY: begin
                idx = first_holding(key);
                if (list_vals.size() == 0) st = ST_EMPTY;
                else if (idx < 0) st = ST_NOTFOUND;
                else list_vals.delete(idx);
            end
            ACT_SEARCH: begin
                if (first_holding(key) < 0) st = ST_NOTFOUND;
                else fnd = 1'b1;
            end
            default: begin
                traversals++;
                if (list_vals.size() == 0) st = ST_EMPTY;
                for (int i = 0; i < list_vals.size(); i++)
                    predicted.push_back(make_reply(ST_OK, 1'b0, list_vals[i],
                                                   i == list_vals.size() - 1));
            end
        endcase
        if (predicted.size() == 0)
            predicted.push_back(make_reply(st, fnd, '0, 1'b1));
        case (st)
            ST_FULL:     full_refusals++;
            ST_EMPTY:    empty_errors++;
            ST_NOTFOUND: key_misses++;
            default: ;
        endcase
        if (list_vals.size() > max_depth)
            max_depth = list_vals.size();
    endfunction

    // Offer one request, hold it until the transfer, then book its replies
    task automatic offer_request(req_row_t rq);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= {rq.value, rq.key};
        s_tuser  <= rq.act;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        apply_request(rq.act, rq.key, rq.value);
        if (rq.typed)
            pending_replies.push_back(rq.reply);
        else
            foreach (predicted[i])
                pending_replies.push_back(predicted[i]);
        requests_sent++;
        // sender idle burst, skipped while the receiver holds off
        if (!no_idle && !rx_holding && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 17);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Half small values so keys repeat, the rest extremes and full-range values
    function automatic word_t pick_value();
        int t;
        t = $urandom_range(0, 99);
        if (t < 50) return $urandom_range(0, 9) - 5;
        if (t < 60) return W_MAX;
        if (t < 70) return W_MIN;
        return $urandom;
    endfunction

    function automatic word_t pick_key();
        if (list_vals.size() > 0 && $urandom_range(0, 9) < 7)
            return list_vals[$urandom_range(0, list_vals.size() - 1)];
        return pick_value();
    endfunction

    // Fill to full, drain to empty, with searches, traverses and random ops
    task automatic pick_random_request(output logic [ACT_W-1:0] act, output word_t key,
                                       output word_t val);
        int r;
        bit add;
        if (growing && list_vals.size() >= CAP && $urandom_range(0, 2) == 0)
            growing = 1'b0;
        else if (!growing && list_vals.size() == 0 && $urandom_range(0, 2) == 0)
            growing = 1'b1;
        key = pick_key();
        val = pick_value();
        r   = $urandom_range(0, 99);
        if (r < 10) begin
            act = ACT_W'($urandom_range(0, 7));
            key = $urandom;
            val = $urandom;
        end else if (r < 20) begin
            act = ACT_TRAVERSE;
        end else if (r < 30) begin
            act = ACT_SEARCH;
        end else begin
            add = (r < 85) ? growing : !growing;
            case ($urandom_range(0, 2))
                0:       act = add ? ACT_INS_FRONT : ACT_DEL_FRONT;
                1:       act = add ? ACT_INS_BACK  : ACT_DEL_BACK;
                default: act = add ? ACT_INS_AFTER : ACT_DEL_KEY;
            endcase
        end
    endtask

    // Compare one result transfer with the oldest expectation
    task automatic check_result();
        reply_t exp_r;
        if (pending_replies.size() == 0) begin
            $error("result with nothing expected: item_value %0d", $signed(m_tdata));
            err_count++;
        end else begin
            exp_r = pending_replies.pop_front();
            if (m_tuser[1:0] !== exp_r.status) begin
                $error("status: expected %0d, got %0d", exp_r.status, m_tuser[1:0]);
                err_count++;
            end
            if (m_tuser[2] !== exp_r.found) begin
                $error("found: expected %0d, got %0d", exp_r.found, m_tuser[2]);
                err_count++;
            end
            if ($signed(m_tdata) !== exp_r.item_value) begin
                $error("item_value: expected %0d, got %0d", exp_r.item_value,
                       $signed(m_tdata));
                err_count++;
            end
            if (m_tlast !== exp_r.last) begin
                $error("last: expected %0d, got %0d", exp_r.last, m_tlast);
                err_count++;
            end
        end
        results_checked++;
    endtask

    // Stimulus: reset, directed table, random requests, drain
    initial begin
        logic [ACT_W-1:0] act;
        word_t key;
        word_t val;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        dir_rows = '{
            row_chk (ACT_DEL_FRONT, 0, 0, ST_EMPTY, 1'b0),
            row_chk (ACT_DEL_BACK, 0, 0, ST_EMPTY, 1'b0),
            row_chk (ACT_DEL_KEY, 5, 0, ST_EMPTY, 1'b0),
            row_chk (ACT_SEARCH, 0, 0, ST_NOTFOUND, 1'b0),
            row_chk (ACT_TRAVERSE, 0, 0, ST_EMPTY, 1'b0),
            row_chk (ACT_INS_AFTER, 0, 1, ST_NOTFOUND, 1'b0),
            row_chk (ACT_INS_FRONT, 0, W_MAX, ST_OK, 1'b0),
            row_chk (ACT_INS_BACK, W_MAX, W_MIN, ST_OK, 1'b0),
            row_pred(ACT_INS_AFTER, W_MAX, -1),
            row_pred(ACT_INS_AFTER, W_MIN, 0),
            row_pred(ACT_INS_FRONT, 0, -1),
            row_chk (ACT_SEARCH, W_MIN, 0, ST_OK, 1'b1),
            row_chk (ACT_SEARCH, 7, 0, ST_NOTFOUND, 1'b0),
            row_pred(ACT_TRAVERSE, 0, 0),
            row_pred(ACT_DEL_KEY, -1, 0),
            row_chk (ACT_DEL_KEY, 32'sh1234_5678, 0, ST_NOTFOUND, 1'b0),
            row_pred(ACT_INS_AFTER, -1, 32'sh5555_5555),
            row_pred(ACT_DEL_KEY, 0, 0),
            row_pred(ACT_DEL_BACK, 0, 0),
            row_pred(ACT_DEL_FRONT, 0, 0),
            row_pred(ACT_TRAVERSE, 32'shaaaa_aaaa, 32'sh5555_5555),
            row_pred(ACT_SEARCH, 32'sh5555_5555, 0)
        };
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i])
            offer_request(dir_rows[i]);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            no_idle = (n >= RANDOM_ITEMS - CALM_ITEMS);
            pick_random_request(act, key, val);
            offer_request(row_pred(act, key, val));
        end
        s_tvalid <= 1'b0;

        // wait for every owed reply, then a little longer for strays
        while (pending_replies.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (pending_replies.size() != 0) begin
            $error("%0d expected results never arrived", pending_replies.size());
            err_count++;
        end

        $display("Covered %0d requests and %0d results; list reached %0d of %0d entries.",
                 requests_sent, results_checked, max_depth, CAP);
        $display("Refused when full %0d, empty %0d, key missing %0d; traversals %0d.",
                 full_refusals, empty_errors, key_misses, traversals);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Result side: random stalls plus one long hold-off that backs the block up
    initial begin
        int stall_left;
        int hold_left;
        bit hold_done;
        logic ready_next;
        stall_left = 0;
        hold_left  = 0;
        hold_done  = 1'b0;
        m_tready  <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready)
                check_result();
            if (!hold_done && !no_idle && results_checked >= HOLD_AFTER) begin
                hold_done  = 1'b1;
                hold_left  = LONG_HOLD;
                rx_holding = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                ready_next = 1'b0;
                if (hold_left == 0)
                    rx_holding = 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                ready_next = 1'b0;
            end else if (!no_idle && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(1, 17) - 1;
                ready_next = 1'b0;
            end else begin
                ready_next = 1'b1;
            end
            m_tready <= ready_next;
        end
    end

    // Watchdog on cycles without any transfer
    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= QUIET_LIMIT) begin
                $display("Timeout: no transfer for %0d cycles", QUIET_LIMIT);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

endmodule

>>> filelist.f
rtl/core/lle_pkg.sv
rtl/core/lle_cell.sv
rtl/core/linked_list_engine_top.sv
tb/sv/tb_linked_list_engine_top.sv
